[rtl/core/rtkl_pkg.sv]
// Package: shared types, field widths and codes for the radix trie key index lookup.
package rtkl_pkg;

    localparam int NODE_DEPTH_DEF  = 4096;
    localparam int CHILD_DEPTH_DEF = 4096;
    localparam int LABEL_DEPTH_DEF = 16384;
    localparam int INDEX_WIDTH_DEF = 16;

    localparam int NODE_ID_W  = 12;
    localparam int OFFSET_W   = 14;
    localparam int LEN_W      = 14;
    localparam int CSTART_W   = 13;
    localparam int CCOUNT_W   = 13;
    localparam int BYTE_W     = 8;
    localparam int PREFIX_W   = 16;
    localparam int ENTRY_A_W  = 14;
    localparam int ENTRY_V_W  = 16;
    localparam int KEY_IDX_W  = 16;
    localparam int LPOS_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // table selects
    localparam logic [3:0] TBL_LABEL      = 4'd0;
    localparam logic [3:0] TBL_NODE_OFF   = 4'd1;
    localparam logic [3:0] TBL_NODE_LEN   = 4'd2;
    localparam logic [3:0] TBL_NODE_TERM  = 4'd3;
    localparam logic [3:0] TBL_NODE_START = 4'd4;
    localparam logic [3:0] TBL_NODE_COUNT = 4'd5;
    localparam logic [3:0] TBL_CHILD_BYTE = 4'd6;
    localparam logic [3:0] TBL_CHILD_ID   = 4'd7;
    localparam logic [3:0] TBL_CHILD_PFX  = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TERMINAL = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [3:0]           table_select;
        logic [ENTRY_A_W-1:0] entry_address;
        logic [ENTRY_V_W-1:0] entry_value;
        logic [BYTE_W-1:0]    key_byte;
        logic                 last_byte;
    } req_item_t;

    typedef struct packed {
        logic                 found;
        logic [KEY_IDX_W-1:0] key_index;
    } rsp_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_item_t;

endpackage

[rtl/core/rtkl_if.sv]
// Interfaces: request, response and configuration channels with valid/ready.
interface rtkl_req_if import rtkl_pkg::*;;
    logic      valid;
    logic      ready;
    req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtkl_rsp_if import rtkl_pkg::*;;
    logic      valid;
    logic      ready;
    rsp_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtkl_cfg_if import rtkl_pkg::*;;
    logic      valid;
    logic      ready;
    cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/rtkl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rtkl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/core/radix_trie_key_index_lookup.sv]
// Top level: radix trie key lookup giving each stored key its minimal perfect hash index.
// Table writes go to the RAMs; a byte of a failed key only passes S_STEP, one inside
// a label reads the label, one at a node boundary reads the node, binary-searches its
// children and reads the child node and label. A last byte or empty-key query then hands
// off, held while a prior result waits; it shows on rsp the cycle after. One item at a time.
// Reset (rst_n low, async) clears control state; table contents are undefined until written.
module radix_trie_key_index_lookup
    import rtkl_pkg::*;
#(
    parameter int NODE_DEPTH  = NODE_DEPTH_DEF,
    parameter int CHILD_DEPTH = CHILD_DEPTH_DEF,
    parameter int LABEL_DEPTH = LABEL_DEPTH_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input logic   clk,
    input logic   rst_n,
    rtkl_req_if.sink   req,
    rtkl_rsp_if.source rsp,
    rtkl_cfg_if.sink   cfg
);
    localparam int NA_W = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int CA_W = (CHILD_DEPTH > 1) ? $clog2(CHILD_DEPTH) : 1;
    localparam int LA_W = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;

    // One-hot sequencer states
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_STEP    = 9'b000000010,  // decide: enter child, match label, or finish
        S_NODE_D  = 9'b000000100,  // parent node entry ready
        S_SRCH    = 9'b000001000,  // issue one binary search probe
        S_SRCH_D  = 9'b000010000,  // probe result: narrow lo/hi
        S_PICK_D  = 9'b000100000,  // final candidate child ready
        S_CHILD_D = 9'b001000000,  // child node entry ready
        S_LABEL_D = 9'b010000000,  // label byte ready
        S_RESULT  = 9'b100000000   // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [NODE_ID_W-1:0] node_count_reg;
    logic [KEY_IDX_W-1:0] key_count_reg;
    logic                 root_term_reg;

    // Lookup state
    logic [NODE_ID_W-1:0]   cur_reg, cur_next;
    logic [INDEX_WIDTH-1:0] acc_reg, acc_next;
    logic [LPOS_W-1:0]      pos_reg, pos_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic                   at_start_reg, at_start_next;
    logic                   failed_reg, failed_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic [CSTART_W-1:0]    start_reg, start_next;
    logic [CCOUNT_W-1:0]    count_reg, count_next;
    logic [CCOUNT_W-1:0]    lo_reg, lo_next;
    logic [CCOUNT_W-1:0]    hi_reg, hi_next;
    logic [CCOUNT_W-1:0]    mid_reg, mid_next;
    logic                   pterm_reg, pterm_next;
    logic [PREFIX_W-1:0]    prefix_reg, prefix_next;
    logic                   res_found_reg, res_found_next;
    logic [KEY_IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_item_t              out_data_reg, out_data_next;

    // Read-range flags: a read outside a table returns zero
    logic node_ok_reg, child_ok_reg, label_ok_reg;

    // Read ports
    logic                 node_re, child_re, label_re;
    logic [NODE_ID_W-1:0] node_ra_id;
    logic [CSTART_W:0]    child_ra_flat;
    logic [LPOS_W-1:0]    label_ra_pos;
    logic [31:0]          node_ra_w, child_ra_w, label_ra_w;

    // Raw and gated read data
    logic [OFFSET_W-1:0]  nq_off, nd_off;
    logic [LEN_W-1:0]     nq_len, nd_len;
    logic                 nq_term, nd_term;
    logic [CSTART_W-1:0]  nq_start, nd_start;
    logic [CCOUNT_W-1:0]  nq_count, nd_count;
    logic [BYTE_W-1:0]    cq_fb, cd_fb;
    logic [NODE_ID_W-1:0] cq_id, cd_id;
    logic [PREFIX_W-1:0]  cq_pfx, cd_pfx;
    logic [BYTE_W-1:0]    lq_byte, ld_byte;

    // Write side
    logic        req_xfer, wr_go, node_wok, child_wok, label_wok;
    logic [31:0] wr_addr_w;

    logic [CCOUNT_W:0] lo_hi_sum;
    logic [31:0]       acc_sum;
    logic              finish_fail;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign req_xfer  = req.valid && req.ready;
    assign wr_go     = req_xfer && (req.data.kind == KIND_WRITE);
    assign wr_addr_w = 32'(req.data.entry_address);
    assign node_wok  = wr_addr_w < 32'(NODE_DEPTH);
    assign child_wok = wr_addr_w < 32'(CHILD_DEPTH);
    assign label_wok = wr_addr_w < 32'(LABEL_DEPTH);

    assign node_ra_w  = 32'(node_ra_id);
    assign child_ra_w = 32'(child_ra_flat);
    assign label_ra_w = 32'(label_ra_pos);

    // ---------------- table memories ----------------
    rtkl_ram #(.WIDTH(BYTE_W), .DEPTH(LABEL_DEPTH)) u_label (
        .clk(clk), .we(wr_go && label_wok && req.data.table_select == TBL_LABEL),
        .waddr(wr_addr_w[LA_W-1:0]), .wdata(req.data.entry_value[BYTE_W-1:0]),
        .re(label_re), .raddr(label_ra_w[LA_W-1:0]), .rdata(lq_byte));

    rtkl_ram #(.WIDTH(OFFSET_W), .DEPTH(NODE_DEPTH)) u_node_off (
        .clk(clk), .we(wr_go && node_wok && req.data.table_select == TBL_NODE_OFF),
        .waddr(wr_addr_w[NA_W-1:0]), .wdata(req.data.entry_value[OFFSET_W-1:0]),
        .re(node_re), .raddr(node_ra_w[NA_W-1:0]), .rdata(nq_off));

    rtkl_ram #(.WIDTH(LEN_W), .DEPTH(NODE_DEPTH)) u_node_len (
        .clk(clk), .we(wr_go && node_wok && req.data.table_select == TBL_NODE_LEN),
        .waddr(wr_addr_w[NA_W-1:0]), .wdata(req.data.entry_value[LEN_W-1:0]),
        .re(node_re), .raddr(node_ra_w[NA_W-1:0]), .rdata(nq_len));

    rtkl_ram #(.WIDTH(1), .DEPTH(NODE_DEPTH)) u_node_term (
        .clk(clk), .we(wr_go && node_wok && req.data.table_select == TBL_NODE_TERM),
        .waddr(wr_addr_w[NA_W-1:0]), .wdata(req.data.entry_value[0]),
        .re(node_re), .raddr(node_ra_w[NA_W-1:0]), .rdata(nq_term));

    rtkl_ram #(.WIDTH(CSTART_W), .DEPTH(NODE_DEPTH)) u_node_start (
        .clk(clk), .we(wr_go && node_wok && req.data.table_select == TBL_NODE_START),
        .waddr(wr_addr_w[NA_W-1:0]), .wdata(req.data.entry_value[CSTART_W-1:0]),
        .re(node_re), .raddr(node_ra_w[NA_W-1:0]), .rdata(nq_start));

    rtkl_ram #(.WIDTH(CCOUNT_W), .DEPTH(NODE_DEPTH)) u_node_count (
        .clk(clk), .we(wr_go && node_wok && req.data.table_select == TBL_NODE_COUNT),
        .waddr(wr_addr_w[NA_W-1:0]), .wdata(req.data.entry_value[CCOUNT_W-1:0]),
        .re(node_re), .raddr(node_ra_w[NA_W-1:0]), .rdata(nq_count));

    rtkl_ram #(.WIDTH(BYTE_W), .DEPTH(CHILD_DEPTH)) u_child_byte (
        .clk(clk), .we(wr_go && child_wok && req.data.table_select == TBL_CHILD_BYTE),
        .waddr(wr_addr_w[CA_W-1:0]), .wdata(req.data.entry_value[BYTE_W-1:0]),
        .re(child_re), .raddr(child_ra_w[CA_W-1:0]), .rdata(cq_fb));

    rtkl_ram #(.WIDTH(NODE_ID_W), .DEPTH(CHILD_DEPTH)) u_child_id (
        .clk(clk), .we(wr_go && child_wok && req.data.table_select == TBL_CHILD_ID),
        .waddr(wr_addr_w[CA_W-1:0]), .wdata(req.data.entry_value[NODE_ID_W-1:0]),
        .re(child_re), .raddr(child_ra_w[CA_W-1:0]), .rdata(cq_id));

    rtkl_ram #(.WIDTH(PREFIX_W), .DEPTH(CHILD_DEPTH)) u_child_pfx (
        .clk(clk), .we(wr_go && child_wok && req.data.table_select == TBL_CHILD_PFX),
        .waddr(wr_addr_w[CA_W-1:0]), .wdata(req.data.entry_value[PREFIX_W-1:0]),
        .re(child_re), .raddr(child_ra_w[CA_W-1:0]), .rdata(cq_pfx));

    // Out-of-range reads read as zero
    assign nd_off   = node_ok_reg ? nq_off : '0;
    assign nd_len   = node_ok_reg ? nq_len : '0;
    assign nd_term  = node_ok_reg ? nq_term : 1'b0;
    assign nd_start = node_ok_reg ? nq_start : '0;
    assign nd_count = node_ok_reg ? nq_count : '0;
    assign cd_fb    = child_ok_reg ? cq_fb : '0;
    assign cd_id    = child_ok_reg ? cq_id : '0;
    assign cd_pfx   = child_ok_reg ? cq_pfx : '0;
    assign ld_byte  = label_ok_reg ? lq_byte : '0;

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign acc_sum   = 32'(acc_reg) + 32'(prefix_reg) + 32'(pterm_reg);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        at_start_next  = at_start_reg;
        failed_next    = failed_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pterm_next     = pterm_reg;
        prefix_next    = prefix_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        node_re        = 1'b0;
        child_re       = 1'b0;
        label_re       = 1'b0;
        node_ra_id     = cur_reg;
        child_ra_flat  = {1'b0, start_reg} + {1'b0, lo_reg};
        label_ra_pos   = pos_reg;
        finish_fail    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    unique case (req.data.kind)
                        KIND_EMPTY:
                        begin
                            // also aborts a key in progress
                            res_found_next = (key_count_reg != '0) && root_term_reg;
                            res_idx_next   = '0;
                            at_start_next  = 1'b1;
                            state_next     = S_RESULT;
                        end
                        KIND_KEY:
                        begin
                            byte_next  = req.data.key_byte;
                            last_next  = req.data.last_byte;
                            state_next = S_STEP;
                            if (at_start_reg)
                            begin
                                cur_next      = node_count_reg;
                                acc_next      = INDEX_WIDTH'(root_term_reg);
                                pos_next      = '0;
                                rem_next      = '0;
                                failed_next   = 1'b0;
                                at_start_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            // table writes go straight to the RAMs; kind 3 is dropped
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                if (failed_reg)
                begin
                    finish_fail = 1'b1;
                end
                else if (rem_reg == '0)
                begin
                    node_re    = 1'b1;
                    node_ra_id = cur_reg;
                    state_next = S_NODE_D;
                end
                else
                begin
                    label_re     = 1'b1;
                    label_ra_pos = pos_reg;
                    state_next   = S_LABEL_D;
                end
            end
            S_NODE_D:
            begin
                start_next = nd_start;
                count_next = nd_count;
                pterm_next = (cur_reg < node_count_reg) && nd_term;
                lo_next    = '0;
                hi_next    = nd_count;
                if (nd_count == '0)
                begin
                    failed_next = 1'b1;
                    finish_fail = 1'b1;
                end
                else
                begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                child_re = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    mid_next      = lo_hi_sum[CCOUNT_W:1];
                    child_ra_flat = {1'b0, start_reg} + {1'b0, lo_hi_sum[CCOUNT_W:1]};
                    state_next    = S_SRCH_D;
                end
                else
                begin
                    child_ra_flat = {1'b0, start_reg} + {1'b0, lo_reg};
                    state_next    = S_PICK_D;
                end
            end
            S_SRCH_D:
            begin
                if (cd_fb < byte_reg)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_PICK_D:
            begin
                if ((lo_reg >= count_reg) || (cd_fb != byte_reg))
                begin
                    failed_next = 1'b1;
                    finish_fail = 1'b1;
                end
                else
                begin
                    prefix_next = cd_pfx;
                    cur_next    = cd_id;
                    node_re     = 1'b1;
                    node_ra_id  = cd_id;
                    state_next  = S_CHILD_D;
                end
            end
            S_CHILD_D:
            begin
                if (nd_len == '0)
                begin
                    // empty child label: miss
                    failed_next = 1'b1;
                    finish_fail = 1'b1;
                end
                else
                begin
                    acc_next     = acc_sum[INDEX_WIDTH-1:0];
                    pos_next     = LPOS_W'(nd_off);
                    rem_next     = nd_len;
                    label_re     = 1'b1;
                    label_ra_pos = LPOS_W'(nd_off);
                    state_next   = S_LABEL_D;
                end
            end
            S_LABEL_D:
            begin
                if (ld_byte != byte_reg)
                begin
                    failed_next = 1'b1;
                    finish_fail = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    rem_next = rem_reg - 1'b1;
                    if (last_reg)
                    begin
                        // terminal check on the node just matched
                        res_found_next = (key_count_reg != '0) && (rem_reg == LEN_W'(1)) &&
                                         1'b1;
                        node_re        = 1'b1;
                        node_ra_id     = cur_reg;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESULT:
            begin
                // for a last byte the node read issued on entry is ready now
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish_fail)
        begin
            if (last_reg)
            begin
                res_found_next = 1'b0;
                res_idx_next   = '0;
                at_start_next  = 1'b1;
                state_next     = S_RESULT;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    // Set when S_LABEL_D hands a last byte to S_RESULT: the terminal flag comes from the node read issued there
    logic term_pending_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_RESULT) && (!out_valid_reg || rsp.ready))
        begin
            out_valid_next          = 1'b1;
            out_data_next.found     = term_pending_reg ? (res_found_reg && nd_term)
                                                       : res_found_reg;
            out_data_next.key_index = (term_pending_reg && res_found_reg && nd_term)
                                      ? res_idx_reg : (term_pending_reg ? '0 : res_idx_reg);
        end
    end

    logic [31:0] acc_w;
    assign acc_w = 32'(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_count_reg   <= '0;
            key_count_reg    <= '0;
            root_term_reg    <= 1'b0;
            cur_reg          <= '0;
            acc_reg          <= '0;
            pos_reg          <= '0;
            rem_reg          <= '0;
            at_start_reg     <= 1'b1;
            failed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            term_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.data.index)
                    CFG_NODE_COUNT:    node_count_reg <= cfg.data.value[NODE_ID_W-1:0];
                    CFG_KEY_COUNT:     key_count_reg  <= cfg.data.value[KEY_IDX_W-1:0];
                    CFG_ROOT_TERMINAL: root_term_reg  <= cfg.data.value[0];
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == S_RESULT) && (!out_valid_reg || rsp.ready))
            begin
                state_reg        <= S_IDLE;
                term_pending_reg <= 1'b0;
            end
            else
            begin
                state_reg <= state_next;
                if ((state_reg == S_LABEL_D) && (state_next == S_RESULT))
                begin
                    term_pending_reg <= 1'b1;
                end
            end
            cur_reg       <= cur_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            at_start_reg  <= ((state_reg == S_LABEL_D) && (state_next == S_RESULT))
                             ? 1'b1 : at_start_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        start_reg     <= start_next;
        count_reg     <= count_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pterm_reg     <= pterm_next;
        prefix_reg    <= prefix_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= ((state_reg == S_LABEL_D) && (state_next == S_RESULT))
                         ? acc_w[KEY_IDX_W-1:0] : res_idx_next;
        out_data_reg  <= out_data_next;
        if (node_re)
        begin
            node_ok_reg <= node_ra_w < 32'(NODE_DEPTH);
        end
        if (child_re)
        begin
            child_ok_reg <= child_ra_w < 32'(CHILD_DEPTH);
        end
        if (label_re)
        begin
            label_ok_reg <= label_ra_w < 32'(LABEL_DEPTH);
        end
    end
endmodule

[test/rtkl_lookup_checker.sv]
// Checker: mirrors the trie tables, predicts each lookup result and compares it with the block.
module rtkl_lookup_checker
    import rtkl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rtkl_req_if   req,
    rtkl_rsp_if   rsp,
    rtkl_cfg_if   cfg,
    output int    mismatches,
    output int    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // mirrored tables
    bit [BYTE_W-1:0]    label_mem  [LABEL_DEPTH_DEF];
    bit [OFFSET_W-1:0]  offset_mem [NODE_DEPTH_DEF];
    bit [LEN_W-1:0]     length_mem [NODE_DEPTH_DEF];
    bit                 term_mem   [NODE_DEPTH_DEF];
    bit [CSTART_W-1:0]  start_mem  [NODE_DEPTH_DEF];
    bit [CCOUNT_W-1:0]  count_mem  [NODE_DEPTH_DEF];
    bit [BYTE_W-1:0]    fbyte_mem  [CHILD_DEPTH_DEF];
    bit [NODE_ID_W-1:0] cid_mem    [CHILD_DEPTH_DEF];
    bit [PREFIX_W-1:0]  pfx_mem    [CHILD_DEPTH_DEF];

    bit [NODE_ID_W-1:0] node_count;
    bit [15:0]          key_count;
    bit                 root_terminal;

    // walk state of the key in progress
    bit [NODE_ID_W-1:0] cur_node;
    bit [KEY_IDX_W-1:0] run_index;
    int                 label_pos;
    int                 label_left;
    bit                 key_fresh;
    bit                 key_dead;

    rsp_item_t expected_q[$];

    function automatic int child_byte(int a);
        return a < CHILD_DEPTH_DEF ? int'(fbyte_mem[a]) : 0;
    endfunction

    function automatic void restart_walk();
        cur_node   = node_count;
        run_index  = '0;
        label_pos  = 0;
        label_left = 0;
        key_fresh  = 1'b1;
        key_dead   = 1'b0;
    endfunction

    // binary search over the sorted children, then step into the match
    function automatic void descend(bit [7:0] b);
        int parent, start, count, lo, hi, mid, flat, child, llen;
        parent = cur_node;
        start  = start_mem[parent];
        count  = count_mem[parent];
        lo = 0;
        hi = count;
        if (count == 0)
        begin
            key_dead = 1'b1;
            return;
        end
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (child_byte(start + mid) < b) lo = mid + 1;
            else hi = mid;
        end
        if (lo >= count || child_byte(start + lo) != b)
        begin
            key_dead = 1'b1;
            return;
        end
        flat  = start + lo;
        child = flat < CHILD_DEPTH_DEF ? int'(cid_mem[flat]) : 0;
        llen  = length_mem[child];
        if (llen == 0)
        begin
            key_dead = 1'b1;
            return;
        end
        run_index += (flat < CHILD_DEPTH_DEF) ? pfx_mem[flat] : 16'd0;
        if (parent < node_count && term_mem[parent]) run_index += 1'b1;
        label_pos  = offset_mem[child];
        label_left = llen;
        cur_node   = child;
    endfunction

    function automatic void take_item(req_item_t it);
        int        a;
        bit [15:0] v;
        rsp_item_t r;
        a = it.entry_address;
        v = it.entry_value;
        case (it.kind)
            KIND_WRITE:
            begin
                case (it.table_select)
                    TBL_LABEL:      label_mem[a] = v[7:0];
                    TBL_NODE_OFF:   if (a < NODE_DEPTH_DEF) offset_mem[a] = v[13:0];
                    TBL_NODE_LEN:   if (a < NODE_DEPTH_DEF) length_mem[a] = v[13:0];
                    TBL_NODE_TERM:  if (a < NODE_DEPTH_DEF) term_mem[a] = v[0];
                    TBL_NODE_START: if (a < NODE_DEPTH_DEF) start_mem[a] = v[12:0];
                    TBL_NODE_COUNT: if (a < NODE_DEPTH_DEF) count_mem[a] = v[12:0];
                    TBL_CHILD_BYTE: if (a < CHILD_DEPTH_DEF) fbyte_mem[a] = v[7:0];
                    TBL_CHILD_ID:   if (a < CHILD_DEPTH_DEF) cid_mem[a] = v[11:0];
                    TBL_CHILD_PFX:  if (a < CHILD_DEPTH_DEF) pfx_mem[a] = v;
                    default: ;
                endcase
            end
            KIND_EMPTY:
            begin
                r.found     = key_count != 0 && root_terminal;
                r.key_index = '0;
                expected_q.push_back(r);
                restart_walk();
            end
            KIND_KEY:
            begin
                if (key_fresh)
                begin
                    restart_walk();
                    key_fresh = 1'b0;
                    run_index = root_terminal ? 16'd1 : 16'd0;
                end
                if (!key_dead && label_left == 0) descend(it.key_byte);
                if (!key_dead)
                begin
                    if ((label_pos < LABEL_DEPTH_DEF ? label_mem[label_pos] : 8'd0)
                        != it.key_byte)
                        key_dead = 1'b1;
                    else
                    begin
                        label_pos++;
                        label_left--;
                    end
                end
                if (it.last_byte)
                begin
                    r.found = !key_dead && key_count != 0 && label_left == 0 &&
                              term_mem[cur_node];
                    r.key_index = r.found ? run_index : '0;
                    expected_q.push_back(r);
                    restart_walk();
                end
            end
            default: ;
        endcase
    endfunction

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count    <= '0;
            key_count     <= '0;
            root_terminal <= 1'b0;
            cur_node   = '0;
            run_index  = '0;
            label_pos  = 0;
            label_left = 0;
            key_fresh  = 1'b1;
            key_dead   = 1'b0;
            expected_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t unexpected result found=%0b index=%0d",
                                 $realtime, rsp.data.found, rsp.data.key_index);
                    mismatches++;
                end
                else if (rsp.data.found !== expected_q[0].found ||
                         rsp.data.key_index !== expected_q[0].key_index)
                begin
                    if (mismatches < 10)
                        $display("%0t result mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                                 $realtime, expected_q[0].found, expected_q[0].key_index,
                                 rsp.data.found, rsp.data.key_index);
                    mismatches++;
                    void'(expected_q.pop_front());
                end
                else
                    void'(expected_q.pop_front());
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.index)
                    CFG_NODE_COUNT:    node_count    <= cfg.data.value[11:0];
                    CFG_KEY_COUNT:     key_count     <= cfg.data.value;
                    CFG_ROOT_TERMINAL: root_terminal <= cfg.data.value[0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready) take_item(req.data);
            outstanding = expected_q.size();
        end
    end

endmodule

[test/radix_trie_key_index_lookup_tb.sv]
// Testbench top: builds random tries, drives table writes and key lookups, reports the verdict.
module radix_trie_key_index_lookup_tb;
    import rtkl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROOT      = 16;   // generator slot of the virtual root
    localparam int MAX_REAL  = 8;
    localparam int IDLE_LIM  = 2000; // cycles without any transfer before giving up

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rtkl_req_if req_ch();
    rtkl_rsp_if rsp_ch();
    rtkl_cfg_if cfg_ch();

    int mismatches;
    int outstanding;

    radix_trie_key_index_lookup dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    rtkl_lookup_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // trie under construction; slots 0..n_real-1 are real nodes, slot ROOT the virtual root
    int        n_real;
    int        node_cfg;
    bit [7:0]  lab      [17][4];
    int        lab_len  [17];
    bit        term     [17];
    int        kids     [17][16];
    int        nkids    [17];
    int        cstart   [17];
    int        loff     [17];

    int  items_sent;
    bit  burst;      // no sender or receiver gaps in this phase
    bit  hold_req;   // receiver should stall for a long stretch once

    // watchdog: any transfer on any channel counts as progress
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIM)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random back-pressure, one long hold when asked
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = burst ? 0 : $urandom_range(0, 4);
                if (n != 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // one request transfer, preceded by a random gap; valid stays high across back-to-back items
    task automatic send_item(req_item_t it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // table write; bits above the table width carry noise the block must drop
    task automatic put_entry(logic [3:0] sel, int addr, bit [15:0] val);
        req_item_t it;
        bit [15:0] mask;
        case (sel)
            TBL_LABEL, TBL_CHILD_BYTE:      mask = 16'h00FF;
            TBL_NODE_OFF, TBL_NODE_LEN:     mask = 16'h3FFF;
            TBL_NODE_TERM:                  mask = 16'h0001;
            TBL_NODE_START, TBL_NODE_COUNT: mask = 16'h1FFF;
            TBL_CHILD_ID:                   mask = 16'h0FFF;
            default:                        mask = 16'hFFFF;
        endcase
        it = req_item_t'($urandom);
        it.kind          = KIND_WRITE;
        it.table_select  = sel;
        it.entry_address = addr[13:0];
        it.entry_value   = (val & mask) | (16'($urandom) & ~mask);
        send_item(it);
    endtask

    // items the block has to drop: kind three, unknown tables, node/child writes past depth
    task automatic send_noise();
        req_item_t it;
        it = req_item_t'({$urandom, $urandom});
        case ($urandom_range(0, 2))
            0: it.kind = 2'd3;
            1:
            begin
                it.kind = KIND_WRITE;
                it.table_select = 4'($urandom_range(9, 15));
            end
            default:
            begin
                it.kind = KIND_WRITE;
                it.table_select = 4'($urandom_range(1, 8));
                it.entry_address = 14'($urandom_range(4096, 16383));
            end
        endcase
        send_item(it);
    endtask

    task automatic send_empty_query();
        req_item_t it;
        it = req_item_t'({$urandom, $urandom});
        it.kind = KIND_EMPTY;
        send_item(it);
    endtask

    task automatic set_config(int nodes, int keys, bit rterm);
        int first;
        int k;
        cfg_item_t c;
        first = $urandom_range(0, 2);
        for (k = 0; k < 3; k++)
        begin
            case ((first + k) % 3)
                0: c = '{index: CFG_NODE_COUNT, value: 16'(nodes) | 16'h0000};
                1: c = '{index: CFG_KEY_COUNT, value: 16'(keys)};
                default: c = '{index: CFG_ROOT_TERMINAL, value: {15'($urandom), rterm}};
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= c;
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        node_cfg = nodes;
    endtask

    function automatic int node_id(int g);
        return g == ROOT ? node_cfg : g;
    endfunction

    // random trie: distinct sorted first bytes per parent, contiguous child blocks
    task automatic build_trie(bit allow_empty_label, bit high_labels);
        int i, j, p, pos, slot, lpos, g, c;
        bit taken;
        n_real = node_cfg == 0 ? 0 :
                 $urandom_range(1, node_cfg < MAX_REAL ? node_cfg : MAX_REAL);
        for (g = 0; g < 17; g++) nkids[g] = 0;
        lab_len[ROOT] = 0;
        term[ROOT] = 1'($urandom_range(0, 1));
        for (i = 0; i < n_real; i++)
        begin
            p = $urandom_range(0, i);
            if (p == i) p = ROOT;
            lab_len[i] = (allow_empty_label && $urandom_range(0, 5) == 0) ? 0 :
                         $urandom_range(1, 3);
            for (j = 0; j < 4; j++) lab[i][j] = 8'($urandom);
            do
            begin
                lab[i][0] = 8'($urandom);
                taken = 1'b0;
                for (j = 0; j < nkids[p]; j++)
                    if (lab[kids[p][j]][0] == lab[i][0]) taken = 1'b1;
            end
            while (taken);
            term[i] = 1'($urandom_range(0, 1));
            // sorted insert by first byte
            pos = nkids[p];
            while (pos > 0 && lab[kids[p][pos-1]][0] > lab[i][0])
            begin
                kids[p][pos] = kids[p][pos-1];
                pos--;
            end
            kids[p][pos] = i;
            nkids[p]++;
        end

        slot = $urandom_range(0, 4000);
        lpos = high_labels ? 16383 - 3 * MAX_REAL : $urandom_range(0, 16383 - 3 * MAX_REAL);
        for (g = 0; g < 17; g++)
        begin
            if (g < n_real || g == ROOT)
            begin
                cstart[g] = slot;
                slot += nkids[g];
                loff[g] = lpos;
                lpos += lab_len[g];
                for (j = 0; j < lab_len[g]; j++)
                    put_entry(TBL_LABEL, loff[g] + j, 16'(lab[g][j]));
                put_entry(TBL_NODE_OFF,   node_id(g), 16'(loff[g]));
                put_entry(TBL_NODE_LEN,   node_id(g), 16'(lab_len[g]));
                put_entry(TBL_NODE_TERM,  node_id(g), 16'(term[g]));
                put_entry(TBL_NODE_START, node_id(g), 16'(cstart[g]));
                put_entry(TBL_NODE_COUNT, node_id(g), 16'(nkids[g]));
                for (j = 0; j < nkids[g]; j++)
                begin
                    c = kids[g][j];
                    put_entry(TBL_CHILD_BYTE, cstart[g] + j, 16'(lab[c][0]));
                    put_entry(TBL_CHILD_ID,   cstart[g] + j, 16'(node_id(c)));
                    put_entry(TBL_CHILD_PFX,  cstart[g] + j, 16'($urandom));
                end
            end
        end
        // padding after the last child block, so any probe one past the end is defined
        for (j = 0; j < 2; j++)
        begin
            put_entry(TBL_CHILD_BYTE, slot + j, 16'hFF);
            put_entry(TBL_CHILD_ID,   slot + j, 16'd0);
            put_entry(TBL_CHILD_PFX,  slot + j, 16'd0);
        end
    endtask

    // a key along a random trie path, mostly exact, sometimes broken
    task automatic send_key();
        bit [7:0] kb[$];
        int g, c, j, v;
        req_item_t it;
        g = ROOT;
        while (nkids[g] > 0 && $urandom_range(0, 4) != 0)
        begin
            c = kids[g][$urandom_range(0, nkids[g] - 1)];
            if (lab_len[c] == 0)
            begin
                kb.push_back(lab[c][0]);  // zero-length label: entering it must miss
                break;
            end
            for (j = 0; j < lab_len[c]; j++) kb.push_back(lab[c][j]);
            g = c;
        end
        v = $urandom_range(0, 99);
        if (v >= 90 || kb.size() == 0)
        begin
            kb.delete();
            repeat ($urandom_range(1, 4)) kb.push_back(8'($urandom));
        end
        else if (v >= 80)
            kb.push_back(8'($urandom));          // runs past the node
        else if (v >= 70)
            kb[$urandom_range(0, kb.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        else if (v >= 60 && kb.size() > 1)
            void'(kb.pop_back());                // ends inside a label or early
        for (j = 0; j < kb.size(); j++)
        begin
            // dropped items and a rare abort by the empty-key query inside a key
            if (j > 0 && $urandom_range(0, 14) == 0) send_noise();
            if (j > 0 && $urandom_range(0, 59) == 0) send_empty_query();
            it = req_item_t'({$urandom, $urandom});
            it.kind      = KIND_KEY;
            it.key_byte  = kb[j];
            it.last_byte = (j == kb.size() - 1);
            send_item(it);
        end
    endtask

    // all results in, then enough quiet cycles for any item without a result to finish
    task automatic drain();
        while (outstanding != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int nodes, keys;
        bit rterm;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        items_sent = 0;
        burst = 1'b0;
        hold_req = 1'b0;
        node_cfg = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // an empty-key query and a key against the reset setting (no keys, root not stored)
        send_empty_query();
        put_entry(TBL_NODE_START, 0, 16'd0);
        put_entry(TBL_NODE_COUNT, 0, 16'd0);
        put_entry(TBL_NODE_TERM, 0, 16'd1);
        send_noise();
        send_item('{kind: KIND_KEY, table_select: 4'hF, entry_address: 14'h3FFF,
                    entry_value: 16'hFFFF, key_byte: 8'hFF, last_byte: 1'b1});
        req_ch.valid <= 1'b0;
        drain();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin nodes = 0;    keys = 0;     rterm = 1'b0; end
                1: begin nodes = 4095; keys = 65535; rterm = 1'b1; end
                2: begin nodes = 6;    keys = 1;     rterm = 1'b0; end
                3: begin nodes = 12;   keys = 0;     rterm = 1'b1; end
                4: begin nodes = 4095; keys = 1;     rterm = 1'b1; end
                default:
                begin
                    nodes = $urandom_range(1, 4095);
                    keys  = $urandom_range(1, 65535);
                    rterm = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(nodes, keys, rterm);
            burst = (ph == 3);
            build_trie(ph == 1 || ph >= 4, ph == 4);
            if (ph == 2) hold_req = 1'b1;  // block fills up while the receiver stalls
            send_empty_query();
            while (items_sent < 120 * (ph + 1) + 80)
            begin
                if ($urandom_range(0, 19) == 0) send_empty_query();
                else send_key();
            end
            req_ch.valid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/core/rtkl_pkg.sv
rtl/core/rtkl_if.sv
rtl/core/rtkl_ram.sv
rtl/core/radix_trie_key_index_lookup.sv
test/rtkl_lookup_checker.sv
test/radix_trie_key_index_lookup_tb.sv
